@@ src/lac_pkg.sv @@
// Shared types, codes and constants of the linear actuator controller.
`default_nettype none

package lac_pkg;

  localparam int TIMER_BITS_DEF = 25;
  localparam int TIME_W         = 24;
  localparam int PCT_W          = 7;
  localparam int CFG_ADDR_W     = 5;
  localparam int CFG_DATA_W     = 32;

  localparam int SPEED_MAX      = 100;
  localparam int MIN_SPEED_MAX  = 99;
  localparam int SPAN_DIV       = 99;
  localparam int PCT_DIV        = 100;
  localparam int SPAN_W         = 15;
  localparam int RECIP_SHIFT    = 22;
  localparam int RECIP_W        = 16;
  localparam logic [RECIP_W-1:0] RECIP_99 =
    RECIP_W'(((1 << RECIP_SHIFT) + SPAN_DIV - 1) / SPAN_DIV);

  localparam logic [7:0] DUTY_BRAKE = 8'd255;
  localparam logic [7:0] DUTY_COAST = 8'd0;

  typedef enum logic [2:0] {
    MODE_RELAXED    = 3'd0,
    MODE_STOPPED    = 3'd1,
    MODE_EXTENDING  = 3'd2,
    MODE_RETRACTING = 3'd3,
    MODE_EXTENDED   = 3'd4,
    MODE_RETRACTED  = 3'd5,
    MODE_TIMEDOUT   = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_EXTEND  = 3'd1,
    ACT_RETRACT = 3'd2,
    ACT_STOP    = 3'd3,
    ACT_RELAX   = 3'd4
  } act_t;

  typedef struct packed {
    logic [2:0] action;
    logic       ext_switch_level;
    logic       ret_switch_level;
  } cmd_t;

  typedef struct packed {
    logic       drive_a;
    logic       drive_b;
    logic [7:0] enable_duty;
    logic       ext_led;
    logic       ret_led;
    logic [2:0] motion_state;
  } rsp_t;

  typedef struct packed {
    logic              normally_open;
    logic              has_feedback;
    logic [TIME_W-1:0] travel_time_ms;
    logic [TIME_W-1:0] timeout_ms;
    logic              force_extended_switch;
    logic              force_retracted_switch;
  } cfg_t;

  typedef struct packed {
    logic              zero;
    logic [7:0]        min_duty;
    logic [SPAN_W-1:0] span;
  } duty_prep_t;

  function automatic logic [MIN_SPEED_MAX:0][7:0] min_duty_tab();
    logic [MIN_SPEED_MAX:0][7:0] tab;
    for (int i = 0; i <= MIN_SPEED_MAX; i++) begin
      tab[i] = 8'((i * 255) / PCT_DIV);
    end
    return tab;
  endfunction

  localparam logic [MIN_SPEED_MAX:0][7:0] MIN_DUTY_TAB = min_duty_tab();

endpackage

`default_nettype wire

@@ src/lac_cfg.sv @@
// Configuration register file with APB access and registered drive-duty preparation.
`default_nettype none

module lac_cfg
  import lac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg,
  output duty_prep_t            prep
);

  typedef enum logic [2:0] {
    REG_SPEED     = 3'd0,
    REG_MIN_SPEED = 3'd1,
    REG_NORM_OPEN = 3'd2,
    REG_FEEDBACK  = 3'd3,
    REG_TRAVEL    = 3'd4,
    REG_TIMEOUT   = 3'd5,
    REG_FORCE_EXT = 3'd6,
    REG_FORCE_RET = 3'd7
  } reg_idx_t;

  logic [PCT_W-1:0]  speed_percent;
  logic [PCT_W-1:0]  min_speed_percent;
  logic              normally_open;
  logic              has_feedback;
  logic [TIME_W-1:0] travel_time_ms;
  logic [TIME_W-1:0] timeout_ms;
  logic              force_extended_switch;
  logic              force_retracted_switch;

  reg_idx_t          idx;
  logic              wr;
  logic [PCT_W-1:0]  speed_clamp;
  logic [PCT_W-1:0]  min_clamp;
  logic [PCT_W-1:0]  speed_m1;
  logic [7:0]        min_duty;
  logic [7:0]        duty_gap;
  duty_prep_t        prep_next;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_percent          <= PCT_W'(SPEED_MAX);
      min_speed_percent      <= PCT_W'(5);
      normally_open          <= 1'b1;
      has_feedback           <= 1'b1;
      travel_time_ms         <= TIME_W'(3000);
      timeout_ms             <= TIME_W'(3000);
      force_extended_switch  <= 1'b0;
      force_retracted_switch <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_SPEED:     speed_percent          <= pwdata[PCT_W-1:0];
        REG_MIN_SPEED: min_speed_percent      <= pwdata[PCT_W-1:0];
        REG_NORM_OPEN: normally_open          <= pwdata[0];
        REG_FEEDBACK:  has_feedback           <= pwdata[0];
        REG_TRAVEL:    travel_time_ms         <= pwdata[TIME_W-1:0];
        REG_TIMEOUT:   timeout_ms             <= pwdata[TIME_W-1:0];
        REG_FORCE_EXT: force_extended_switch  <= pwdata[0];
        REG_FORCE_RET: force_retracted_switch <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SPEED:     prdata = CFG_DATA_W'(speed_percent);
      REG_MIN_SPEED: prdata = CFG_DATA_W'(min_speed_percent);
      REG_NORM_OPEN: prdata = CFG_DATA_W'(normally_open);
      REG_FEEDBACK:  prdata = CFG_DATA_W'(has_feedback);
      REG_TRAVEL:    prdata = CFG_DATA_W'(travel_time_ms);
      REG_TIMEOUT:   prdata = CFG_DATA_W'(timeout_ms);
      REG_FORCE_EXT: prdata = CFG_DATA_W'(force_extended_switch);
      REG_FORCE_RET: prdata = CFG_DATA_W'(force_retracted_switch);
      default:       prdata = '0;
    endcase
  end

  assign cfg.normally_open          = normally_open;
  assign cfg.has_feedback           = has_feedback;
  assign cfg.travel_time_ms         = travel_time_ms;
  assign cfg.timeout_ms             = timeout_ms;
  assign cfg.force_extended_switch  = force_extended_switch;
  assign cfg.force_retracted_switch = force_retracted_switch;

  // clamp, look up minimum duty, form the span numerator
  always_comb begin
    speed_clamp = (speed_percent > PCT_W'(SPEED_MAX)) ? PCT_W'(SPEED_MAX) : speed_percent;
    min_clamp   = (min_speed_percent > PCT_W'(MIN_SPEED_MAX)) ?
                  PCT_W'(MIN_SPEED_MAX) : min_speed_percent;
    min_duty    = MIN_DUTY_TAB[min_clamp];
    speed_m1    = speed_clamp - PCT_W'(1);
    duty_gap    = DUTY_BRAKE - min_duty;
    prep_next.zero     = (speed_clamp == '0);
    prep_next.min_duty = min_duty;
    prep_next.span     = SPAN_W'(speed_m1) * SPAN_W'(duty_gap);
  end

  always_ff @(posedge clk) begin
    prep <= prep_next;
  end

endmodule

`default_nettype wire

@@ src/lac_core.sv @@
// Motion mode state, switch qualification, travel timer and result word logic.
`default_nettype none

module lac_core
  import lac_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  cmd_t       cmd,
  input  cfg_t       cfg,
  input  duty_prep_t prep,
  output rsp_t       rsp_next
);

  localparam int CMP_W  = (TIMER_BITS > TIME_W) ? TIMER_BITS : TIME_W;
  localparam int PROD_W = SPAN_W + RECIP_W;

  mode_t                 mode;
  mode_t                 prev_mode;
  logic                  ext_fb;
  logic                  ret_fb;
  logic [TIMER_BITS-1:0] elapsed;

  mode_t                 mode_next;
  mode_t                 prev_mode_next;
  logic                  ext_fb_next;
  logic                  ret_fb_next;
  logic [TIMER_BITS-1:0] elapsed_next;

  logic                  arrived;
  logic [CMP_W-1:0]      elapsed_x;
  logic [PROD_W-1:0]     span_prod;
  logic [7:0]            drive_duty;

  always_comb begin
    mode_next      = mode;
    prev_mode_next = prev_mode;
    ext_fb_next    = ext_fb;
    ret_fb_next    = ret_fb;
    elapsed_next   = elapsed;
    arrived        = 1'b0;
    elapsed_x      = '0;
    unique case (cmd.action)
      ACT_TICK: begin
        ext_fb_next = (cmd.ext_switch_level != cfg.normally_open) ||
                      cfg.force_extended_switch;
        ret_fb_next = (cmd.ret_switch_level != cfg.normally_open) ||
                      cfg.force_retracted_switch;
        if ((mode == MODE_EXTENDING) || (mode == MODE_RETRACTING)) begin
          arrived = (mode == MODE_EXTENDING) ? (ext_fb_next && !ret_fb_next) :
                                               (ret_fb_next && !ext_fb_next);
          if (mode != prev_mode) begin
            elapsed_next = '0;
          end else if (elapsed != '1) begin
            elapsed_next = elapsed + TIMER_BITS'(1);
          end
          prev_mode_next = mode;
          elapsed_x      = CMP_W'(elapsed_next);
          if (cfg.has_feedback && (cfg.timeout_ms != '0) &&
              (elapsed_x >= CMP_W'(cfg.timeout_ms))) begin
            mode_next = MODE_TIMEDOUT;
          end
          if ((cfg.has_feedback && arrived) ||
              (!cfg.has_feedback && (elapsed_x >= CMP_W'(cfg.travel_time_ms)))) begin
            mode_next = (mode == MODE_EXTENDING) ? MODE_EXTENDED : MODE_RETRACTED;
          end
        end else begin
          prev_mode_next = mode;
        end
      end
      ACT_EXTEND: begin
        if (!ext_fb) mode_next = MODE_EXTENDING;
      end
      ACT_RETRACT: begin
        if (!ret_fb) mode_next = MODE_RETRACTING;
      end
      ACT_STOP:  mode_next = MODE_STOPPED;
      ACT_RELAX: mode_next = MODE_RELAXED;
      default: ;
    endcase
  end

  // floor(span / 99) by reciprocal multiply, then add minimum duty
  always_comb begin
    span_prod  = PROD_W'(prep.span) * PROD_W'(RECIP_99);
    drive_duty = prep.zero ? DUTY_COAST :
                 span_prod[RECIP_SHIFT+7:RECIP_SHIFT] + prep.min_duty;
  end

  always_comb begin
    rsp_next.drive_a      = (mode_next == MODE_EXTENDING);
    rsp_next.drive_b      = (mode_next == MODE_RETRACTING);
    rsp_next.ext_led      = ext_fb_next;
    rsp_next.ret_led      = ret_fb_next;
    rsp_next.motion_state = mode_next;
    unique case (mode_next)
      MODE_EXTENDING, MODE_RETRACTING: rsp_next.enable_duty = drive_duty;
      MODE_RELAXED:                    rsp_next.enable_duty = DUTY_COAST;
      default:                         rsp_next.enable_duty = DUTY_BRAKE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_RELAXED;
      prev_mode <= MODE_RELAXED;
      ext_fb    <= 1'b0;
      ret_fb    <= 1'b0;
      elapsed   <= '0;
    end else if (step) begin
      mode      <= mode_next;
      prev_mode <= prev_mode_next;
      ext_fb    <= ext_fb_next;
      ret_fb    <= ret_fb_next;
      elapsed   <= elapsed_next;
    end
  end

endmodule

`default_nettype wire

@@ src/linear_actuator_controller_top.sv @@
// Top level of the linear actuator controller: word registers, handshake and submodules.
//
//   channel  dir  handshake             payload
//   cmd      in   cmd_valid/cmd_stall   cmd_data (lac_pkg::cmd_t)
//   rsp      out  rsp_valid/rsp_stall   rsp_data (lac_pkg::rsp_t)
//   apb      in   psel/penable/pready   paddr, pwdata, prdata
//
// One word per clock while rsp_stall is low; a command word is registered in cmd_q
// and its result in rsp_q. The command register and the result register each hold one
// word, so one new word is taken while a finished result waits on rsp_stall.
// rst is synchronous: mode relaxed, timer and feedback cleared, registers at defaults.
// Drive duty is prepared one register ahead of the step logic from the percentages.
`default_nettype none

module linear_actuator_controller_top
  import lac_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  cmd_t                  cmd_data,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_t                  rsp_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t       cfg;
  duty_prep_t prep;
  logic       cmd_full;
  cmd_t       cmd_q;
  logic       rsp_full;
  rsp_t       rsp_q;
  rsp_t       rsp_next;
  logic       step;

  assign step      = cmd_full && (!rsp_full || !rsp_stall);
  assign cmd_stall = cmd_full && !step;
  assign rsp_valid = rsp_full;
  assign rsp_data  = rsp_q;

  lac_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .prep    (prep)
  );

  lac_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .cmd      (cmd_q),
    .cfg      (cfg),
    .prep     (prep),
    .rsp_next (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_full <= 1'b0;
      rsp_full <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        cmd_full <= 1'b1;
      end else if (step) begin
        cmd_full <= 1'b0;
      end
      if (step) begin
        rsp_full <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) cmd_q <= cmd_data;
    if (step) rsp_q <= rsp_next;
  end

endmodule

`default_nettype wire

@@ src/lac_checker.sv @@
// Port-level checks of the linear actuator controller and their binding to the top level.
`default_nettype none

module lac_checker
  import lac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_stall,
  input  logic                  rsp_valid,
  input  logic                  rsp_stall,
  input  rsp_t                  rsp_data
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("stalled result word changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid && !cmd_stall)
    else $error("words present after reset");

  a_drive_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_data.drive_a && rsp_data.drive_b) &&
                  (rsp_data.drive_a == (rsp_data.motion_state == MODE_EXTENDING)) &&
                  (rsp_data.drive_b == (rsp_data.motion_state == MODE_RETRACTING)))
    else $error("bridge pins disagree with motion state");

  a_coast: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.motion_state == MODE_RELAXED) |->
      (rsp_data.enable_duty == DUTY_COAST))
    else $error("relaxed state without coast duty");

  a_brake: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && ((rsp_data.motion_state == MODE_STOPPED) ||
                  (rsp_data.motion_state == MODE_EXTENDED) ||
                  (rsp_data.motion_state == MODE_RETRACTED) ||
                  (rsp_data.motion_state == MODE_TIMEDOUT)) |->
      (rsp_data.enable_duty == DUTY_BRAKE))
    else $error("holding state without brake duty");

endmodule

bind linear_actuator_controller_top lac_checker u_lac_checker (.*);

`default_nettype wire
